>>> src/lph_pkg.sv
package lph_pkg;

  localparam int unsigned ActW     = 2;
  localparam int unsigned KeyW     = 32;
  localparam int unsigned HashW    = 32;
  localparam int unsigned ValW     = 64;
  localparam int unsigned StepBits = 4;
  localparam int unsigned LoadNum  = 3;
  localparam int unsigned LoadDen  = 4;

  typedef enum logic [ActW-1:0] {
    ActSet = 2'd0,
    ActGet = 2'd1,
    ActDel = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    SlotEmpty = 2'd0,
    SlotLive  = 2'd1,
    SlotTomb  = 2'd2
  } slot_e;

  typedef enum logic [1:0] {
    StClear = 2'd0,
    StIdle  = 2'd1,
    StHash  = 2'd2,
    StProbe = 2'd3
  } fsm_e;

  typedef struct packed {
    slot_e             st;
    logic [KeyW-1:0]   key;
    logic [ValW-1:0]   data;
  } row_t;

endpackage

>>> src/lph_mod.sv
module lph_mod #(
  parameter int unsigned SLOTS = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [lph_pkg::HashW-1:0]    hash_i,
  output logic                         done_o,
  output logic [$clog2(SLOTS)-1:0]     rem_o
);
  import lph_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned SW = IW + 1;
  localparam int unsigned Steps = HashW / StepBits;
  localparam int unsigned NW = (Steps > 1) ? $clog2(Steps) : 1;

  if ((SLOTS & (SLOTS - 1)) == 0) begin : g_mask
    logic          done_q;
    logic [IW-1:0] rem_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        rem_q <= hash_i[IW-1:0];
      end
    end

    assign done_o = done_q;
    assign rem_o  = rem_q;
  end else begin : g_iter
    logic             run_q;
    logic             done_q;
    logic [NW-1:0]    cnt_q;
    logic [HashW-1:0] sh_q;
    logic [IW-1:0]    r_q;
    logic [IW-1:0]    r_d;

    always_comb begin
      logic [SW-1:0] t;
      r_d = r_q;
      for (int i = 0; i < StepBits; i++) begin
        t = {r_d, sh_q[HashW-1-i]};
        if (t >= SW'(SLOTS)) begin
          t = t - SW'(SLOTS);
        end
        r_d = t[IW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        run_q  <= 1'b0;
        done_q <= 1'b0;
        cnt_q  <= '0;
      end else begin
        done_q <= 1'b0;
        if (start_i) begin
          run_q <= 1'b1;
          cnt_q <= '0;
        end else if (run_q) begin
          cnt_q <= cnt_q + NW'(1);
          if (cnt_q == NW'(Steps - 1)) begin
            run_q  <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        sh_q <= hash_i;
        r_q  <= '0;
      end else if (run_q) begin
        sh_q <= sh_q << StepBits;
        r_q  <= r_d;
      end
    end

    assign done_o = done_q;
    assign rem_o  = r_q;
  end

endmodule

>>> src/lph_mem.sv
module lph_mem #(
  parameter int unsigned SLOTS = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(SLOTS)-1:0] waddr_i,
  input  lph_pkg::row_t            wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(SLOTS)-1:0] raddr_i,
  output lph_pkg::row_t            rdata_o
);
  import lph_pkg::*;

  row_t mem_q [SLOTS];
  row_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/linear_probe_hash_table.sv
// Open-addressing key/value map with linear probing and tombstones. A request (set, get
// or delete) is taken when start is high and busy is low; its single result appears on
// done_o for exactly one cycle and must be captured then, since the receiver cannot
// stall. After reset a clearing pass writes every slot empty, with busy high. The slot
// memory has one read port, so probing reads one slot per cycle. When SLOTS is not a
// power of two, the start slot comes from a remainder unit that retires four hash bits
// a cycle; otherwise it is the low hash bits. A refused set, a get or delete on an empty
// table and an unused action answer from idle, with no hash or probe step. busy is low
// while the result is shown, so the next request may follow it.
module linear_probe_hash_table #(
  parameter int unsigned SLOTS = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [lph_pkg::ActW-1:0]    action_i,
  input  logic [lph_pkg::KeyW-1:0]    key_id_i,
  input  logic [lph_pkg::HashW-1:0]   key_hash_i,
  input  logic [lph_pkg::ValW-1:0]    write_value_i,
  output logic                        done_o,
  output logic                        hit_o,
  output logic [lph_pkg::ValW-1:0]    read_value_o,
  output logic                        table_full_o
);
  import lph_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned LW = CW + 3;

  typedef struct packed {
    logic          fin;
    logic          live;
    logic          free;
    logic          none;
    logic          reuse;
    logic [IW-1:0] where;
  } probe_t;

  fsm_e            state_q, state_d;
  logic [IW-1:0]   clr_q, clr_d;
  action_e         act_q, act_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [ValW-1:0] wval_q, wval_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   iss_q, iss_d;
  logic [CW-1:0]   ev_q, ev_d;
  logic            rvld_q, rvld_d;
  logic [IW-1:0]   eidx_q, eidx_d;
  logic            tomb_have_q, tomb_have_d;
  logic [IW-1:0]   tomb_at_q, tomb_at_d;
  logic [CW-1:0]   occ_q, occ_d;
  logic            done_q, done_d;
  logic            hit_q, hit_d;
  logic [ValW-1:0] rval_q, rval_d;
  logic            full_q, full_d;

  logic            mem_we, mem_re;
  logic [IW-1:0]   mem_waddr, mem_raddr;
  row_t            mem_wdata, rdata;
  logic            mod_start, mod_done;
  logic [IW-1:0]   mod_rem;
  logic            over;
  logic            req_probe;
  logic            is_live, is_tomb;
  probe_t          pr;

  lph_mod #(.SLOTS(SLOTS)) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .hash_i  (key_hash_i),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  lph_mem #(.SLOTS(SLOTS)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  assign over = (LW'(LoadDen) * (LW'(occ_q) + LW'(1))) > LW'(LoadNum * SLOTS);

  always_comb begin
    req_probe = 1'b0;
    if (start && state_q == StIdle) begin
      unique case (action_e'(action_i))
        ActSet:         req_probe = !over;
        ActGet, ActDel: req_probe = (occ_q != '0);
        default:        req_probe = 1'b0;
      endcase
    end
  end

  assign mod_start = req_probe;

  assign is_live = (rdata.st == SlotLive);
  assign is_tomb = (rdata.st == SlotTomb);

  always_comb begin
    pr = '0;
    if (rvld_q) begin
      if (is_live && rdata.key == key_q) begin
        pr.fin   = 1'b1;
        pr.live  = 1'b1;
        pr.where = eidx_q;
      end else if (!is_live && !is_tomb) begin
        pr.fin   = 1'b1;
        pr.free  = 1'b1;
        pr.reuse = tomb_have_q;
        pr.where = tomb_have_q ? tomb_at_q : eidx_q;
      end else if (ev_q == CW'(SLOTS - 1)) begin
        pr.fin   = 1'b1;
        pr.where = tomb_have_q ? tomb_at_q : eidx_q;
        if (tomb_have_q || is_tomb) begin
          pr.free  = 1'b1;
          pr.reuse = 1'b1;
        end else begin
          pr.none = 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: if (clr_q == IW'(SLOTS - 1)) state_d = StIdle;
      StIdle:  if (req_probe) state_d = StHash;
      StHash:  if (mod_done) state_d = StProbe;
      StProbe: if (pr.fin) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    clr_d       = clr_q;
    act_d       = act_q;
    key_d       = key_q;
    wval_d      = wval_q;
    idx_d       = idx_q;
    iss_d       = iss_q;
    ev_d        = ev_q;
    rvld_d      = 1'b0;
    eidx_d      = eidx_q;
    tomb_have_d = tomb_have_q;
    tomb_at_d   = tomb_at_q;
    occ_d       = occ_q;
    done_d      = 1'b0;
    hit_d       = 1'b0;
    rval_d      = '0;
    full_d      = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = eidx_q;
    mem_wdata   = '{st: SlotEmpty, key: '0, data: '0};
    mem_re      = 1'b0;
    mem_raddr   = idx_q;
    unique case (state_q)
      StClear: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + IW'(1);
      end
      StIdle: begin
        if (start) begin
          act_d  = action_e'(action_i);
          key_d  = key_id_i;
          wval_d = write_value_i;
          if (!req_probe) begin
            done_d = 1'b1;
            full_d = (action_e'(action_i) == ActSet);
          end
        end
      end
      StHash: begin
        if (mod_done) begin
          idx_d       = mod_rem;
          iss_d       = '0;
          ev_d        = '0;
          tomb_have_d = 1'b0;
        end
      end
      StProbe: begin
        if (iss_q != CW'(SLOTS)) begin
          mem_re = 1'b1;
          rvld_d = 1'b1;
          eidx_d = idx_q;
          iss_d  = iss_q + CW'(1);
          idx_d  = (idx_q == IW'(SLOTS - 1)) ? '0 : idx_q + IW'(1);
        end
        if (rvld_q) begin
          ev_d = ev_q + CW'(1);
          if (is_tomb && !tomb_have_q) begin
            tomb_have_d = 1'b1;
            tomb_at_d   = eidx_q;
          end
        end
        if (pr.fin) begin
          done_d = 1'b1;
          unique case (act_q)
            ActSet: begin
              if (pr.none) begin
                full_d = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = pr.where;
                mem_wdata = '{st: SlotLive, key: key_q, data: wval_q};
                if (pr.free) begin
                  hit_d = 1'b1;
                  if (!pr.reuse) occ_d = occ_q + CW'(1);
                end
              end
            end
            ActGet: begin
              if (pr.live) begin
                hit_d  = 1'b1;
                rval_d = rdata.data;
              end
            end
            ActDel: begin
              if (pr.live) begin
                hit_d     = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = eidx_q;
                mem_wdata = '{st: SlotTomb, key: rdata.key, data: rdata.data};
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      iss_q       <= '0;
      ev_q        <= '0;
      rvld_q      <= 1'b0;
      tomb_have_q <= 1'b0;
      occ_q       <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      iss_q       <= iss_d;
      ev_q        <= ev_d;
      rvld_q      <= rvld_d;
      tomb_have_q <= tomb_have_d;
      occ_q       <= occ_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    key_q     <= key_d;
    wval_q    <= wval_d;
    idx_q     <= idx_d;
    eidx_q    <= eidx_d;
    tomb_at_q <= tomb_at_d;
    hit_q     <= hit_d;
    rval_q    <= rval_d;
    full_q    <= full_d;
  end

  assign busy         = (state_q != StIdle);
  assign done_o       = done_q;
  assign hit_o        = hit_q;
  assign read_value_o = rval_q;
  assign table_full_o = full_q;

  a_occ_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (LW'(LoadDen) * LW'(occ_q)) <= LW'(LoadNum * SLOTS))
    else $error("occupancy above load limit");

  a_refuse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && action_e'(action_i) == ActSet && over) |=> (done_o && table_full_o))
    else $error("set over load limit not refused");

  a_value_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && read_value_o != '0) |-> (hit_o && !table_full_o))
    else $error("value returned without hit");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

endmodule

>>> tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lph_pkg::*;

  localparam int unsigned Slots      = 256;
  localparam int unsigned PoolSize   = 48;
  localparam int unsigned WatchLimit = 5000;
  localparam int unsigned TailCycles = 300;
  localparam logic [ActW-1:0] ActUnused = 2'd3;

  typedef enum {ProbeLive, ProbeFree, ProbeNone} probe_e;

  typedef struct packed {
    logic            hit;
    logic [ValW-1:0] value;
    logic            full;
  } answer_t;

  typedef struct {
    logic [ActW-1:0]  act;
    logic [KeyW-1:0]  key;
    logic [HashW-1:0] hash;
    logic [ValW-1:0]  wval;
    bit               fixed;
    answer_t          want;
  } step_t;

  localparam answer_t Miss = '{hit: 1'b0, value: 64'd0, full: 1'b0};
  localparam answer_t Hit  = '{hit: 1'b1, value: 64'd0, full: 1'b0};

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start;
  logic             busy;
  logic [ActW-1:0]  action_i;
  logic [KeyW-1:0]  key_id_i;
  logic [HashW-1:0] key_hash_i;
  logic [ValW-1:0]  write_value_i;
  logic             done_o;
  logic             hit_o;
  logic [ValW-1:0]  read_value_o;
  logic             table_full_o;

  slot_e            mirror_state [Slots];
  logic [KeyW-1:0]  mirror_key [Slots];
  logic [ValW-1:0]  mirror_data [Slots];
  int unsigned      mirror_fill;

  logic [KeyW-1:0]  pool_key [PoolSize];
  logic [HashW-1:0] pool_hash [PoolSize];

  answer_t          pending_answers [$];
  step_t            script [22];
  int unsigned      mismatches = 0;
  int unsigned      idle_cycles = 0;

  linear_probe_hash_table #(.SLOTS(Slots)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .action_i     (action_i),
    .key_id_i     (key_id_i),
    .key_hash_i   (key_hash_i),
    .write_value_i(write_value_i),
    .done_o       (done_o),
    .hit_o        (hit_o),
    .read_value_o (read_value_o),
    .table_full_o (table_full_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic probe_e find_slot(input logic [KeyW-1:0] key,
                                       input logic [HashW-1:0] hash,
                                       output int unsigned at);
    int unsigned idx;
    int unsigned tomb_at;
    bit          seen_tomb;
    idx = hash % Slots;
    tomb_at = 0;
    seen_tomb = 1'b0;
    at = 0;
    for (int unsigned n = 0; n < Slots; n++) begin
      if (mirror_state[idx] == SlotLive) begin
        if (mirror_key[idx] == key) begin
          at = idx;
          return ProbeLive;
        end
      end else if (mirror_state[idx] == SlotTomb) begin
        if (!seen_tomb) begin
          seen_tomb = 1'b1;
          tomb_at = idx;
        end
      end else begin
        at = seen_tomb ? tomb_at : idx;
        return ProbeFree;
      end
      idx = (idx + 1) % Slots;
    end
    if (seen_tomb) begin
      at = tomb_at;
      return ProbeFree;
    end
    return ProbeNone;
  endfunction

  function automatic answer_t map_apply(input logic [ActW-1:0] act,
                                        input logic [KeyW-1:0] key,
                                        input logic [HashW-1:0] hash,
                                        input logic [ValW-1:0] wval);
    answer_t     ans;
    probe_e      found;
    int unsigned at;
    ans = Miss;
    case (act)
      ActSet: begin
        if (LoadDen * (mirror_fill + 1) > LoadNum * Slots) begin
          ans.full = 1'b1;
        end else begin
          found = find_slot(key, hash, at);
          if (found == ProbeNone) begin
            ans.full = 1'b1;
          end else begin
            if (found == ProbeFree) begin
              ans.hit = 1'b1;
              if (mirror_state[at] == SlotEmpty) mirror_fill++;
            end
            mirror_state[at] = SlotLive;
            mirror_key[at] = key;
            mirror_data[at] = wval;
          end
        end
      end
      ActGet, ActDel: begin
        if (mirror_fill != 0 && find_slot(key, hash, at) == ProbeLive) begin
          ans.hit = 1'b1;
          if (act == ActGet) ans.value = mirror_data[at];
          else mirror_state[at] = SlotTomb;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  task automatic send(input logic [ActW-1:0] act, input logic [KeyW-1:0] key,
                      input logic [HashW-1:0] hash, input logic [ValW-1:0] wval,
                      input int unsigned gap, input bit fixed, input answer_t want);
    answer_t got;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    action_i      <= act;
    key_id_i      <= key;
    key_hash_i    <= hash;
    write_value_i <= wval;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    got = map_apply(act, key, hash, wval);
    pending_answers.push_back(fixed ? want : got);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_answers.size() != 0);
  endtask

  task automatic run_random(input int unsigned count, input int unsigned fresh_pct);
    int unsigned      roll;
    int unsigned      pick;
    int unsigned      burst_left;
    int unsigned      gap;
    logic [ActW-1:0]  act;
    logic [KeyW-1:0]  key;
    logic [HashW-1:0] hash;
    burst_left = 0;
    for (int unsigned i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) act = ActSet;
      else if (roll < 70) act = ActGet;
      else if (roll < 96) act = ActDel;
      else act = ActUnused;
      pick = $urandom_range(0, PoolSize - 1);
      key = pool_key[pick];
      hash = pool_hash[pick];
      if ($urandom_range(0, 99) < fresh_pct) begin
        key = $urandom;
        hash = $urandom;
      end else if ($urandom_range(0, 15) == 0) begin
        hash = $urandom;
      end
      if (burst_left == 0 && $urandom_range(0, 9) == 0) burst_left = $urandom_range(10, 40);
      if (burst_left > 0) begin
        gap = 0;
        burst_left--;
      end else begin
        gap = $urandom_range(0, 4);
      end
      send(act, key, hash, {$urandom, $urandom}, gap, 1'b0, Miss);
    end
  endtask

  task automatic note_mismatch(input string what, input logic [ValW-1:0] want,
                               input logic [ValW-1:0] got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch %s: expected %h, got %h", what, want, got);
  endtask

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni) begin
      if ((start && !busy) || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
      if (done_o) begin
        if (pending_answers.size() == 0) begin
          note_mismatch("unexpected result, read_value", 64'd0, read_value_o);
        end else begin
          want = pending_answers.pop_front();
          if (hit_o !== want.hit) note_mismatch("hit", 64'(want.hit), 64'(hit_o));
          if (read_value_o !== want.value) note_mismatch("read_value", want.value, read_value_o);
          if (table_full_o !== want.full)
            note_mismatch("table_full", 64'(want.full), 64'(table_full_o));
        end
      end
    end
  end

  initial begin
    start         <= 1'b0;
    action_i      <= ActSet;
    key_id_i      <= '0;
    key_hash_i    <= '0;
    write_value_i <= '0;
    for (int i = 0; i < Slots; i++) begin
      mirror_state[i] = SlotEmpty;
      mirror_key[i] = '0;
      mirror_data[i] = '0;
    end
    mirror_fill = 0;
    for (int i = 0; i < PoolSize; i++) begin
      pool_key[i] = $urandom;
      pool_hash[i] = {24'($urandom), 8'(240 + $urandom_range(0, 31))};
    end
    pool_key[0] = 32'h0000_0000;
    pool_key[1] = 32'hFFFF_FFFF;

    script = '{
      '{ActGet,    32'd1,         32'd5,         64'd0,                 1'b1, Miss},
      '{ActDel,    32'd1,         32'd5,         64'd0,                 1'b1, Miss},
      '{ActUnused, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, Miss},
      '{ActSet,    32'd0,         32'd0,         64'd0,                 1'b1, Hit},
      '{ActSet,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, Hit},
      '{ActGet,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0,                 1'b1,
        '{hit: 1'b1, value: 64'hFFFF_FFFF_FFFF_FFFF, full: 1'b0}},
      '{ActSet,    32'd1,         32'hFFFF_FFFF, 64'hA5A5_A5A5_5A5A_5A5A, 1'b1, Hit},
      '{ActSet,    32'd2,         32'h0000_0100, 64'h0123_4567_89AB_CDEF, 1'b0, Miss},
      '{ActGet,    32'd1,         32'hFFFF_FFFF, 64'd0,                 1'b0, Miss},
      '{ActDel,    32'd0,         32'd0,         64'd0,                 1'b1, Hit},
      '{ActGet,    32'd0,         32'd0,         64'd0,                 1'b1, Miss},
      '{ActGet,    32'd2,         32'h0000_0100, 64'd0,                 1'b0, Miss},
      '{ActDel,    32'd0,         32'd0,         64'd0,                 1'b1, Miss},
      '{ActSet,    32'd3,         32'h0000_0200, 64'hDEAD_BEEF_0000_0001, 1'b0, Miss},
      '{ActSet,    32'd3,         32'h0000_0200, 64'hFEED_F00D_8000_0000, 1'b1, Miss},
      '{ActGet,    32'd3,         32'h0000_0200, 64'd0,                 1'b0, Miss},
      '{ActDel,    32'd2,         32'h0000_0100, 64'd0,                 1'b0, Miss},
      '{ActGet,    32'd7,         32'h0000_0100, 64'd0,                 1'b0, Miss},
      '{ActUnused, 32'd3,         32'h0000_0200, 64'h5555_AAAA_5555_AAAA, 1'b1, Miss},
      '{ActDel,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0,                 1'b0, Miss},
      '{ActSet,    32'h8000_0000, 32'h7FFF_FFFF, 64'h8000_0000_0000_0001, 1'b0, Miss},
      '{ActGet,    32'h8000_0000, 32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, Miss}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      send(script[i].act, script[i].key, script[i].hash, script[i].wval,
           $urandom_range(0, 4), script[i].fixed, script[i].want);
    end
    run_random(900, 10);
    drain();
    run_random(950, 60);
    drain();
    repeat (TailCycles) @(posedge clk_i);

    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> linear_probe_hash_table.f
src/lph_pkg.sv
src/lph_mod.sv
src/lph_mem.sv
src/linear_probe_hash_table.sv
tb/tb.sv
